>>> rtl/core/chi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi_pkg
// Shared widths, constants and types of the cubic Hermite interpolator.
// ----------------------------------------------------------------------------
package chi_pkg;

  // default time fraction bits (Q12.20 seconds)
  localparam int TIME_FRAC_BITS_DEF = 20;

  // result width and quotient bits produced by the divider
  localparam int QBITS = 32;

  // intermediate widths of the numerator datapath (independent of time format)
  localparam int G_W    = 33;   // T - t, or a time zero-extended to signed
  localparam int K_W    = 35;   // 3T - 2t
  localparam int A_W    = 66;   // v0*g - v1*t
  localparam int GA_W   = 99;   // g * A
  localparam int B_W    = 132;  // T * g * A
  localparam int C1_W   = 68;   // dp * k
  localparam int CP_W   = 101;  // dp * k * t
  localparam int TT_W   = 64;   // T^2
  localparam int T3_W   = 98;   // T^3 as a signed product
  localparam int TCUBE_W = 96;  // T^3 magnitude bits
  localparam int PT_W   = 130;  // p0 * T^3

  // saturation limits
  localparam logic [QBITS-1:0] POS_MAX     = 32'h7fff_ffff;
  localparam logic [QBITS-1:0] POS_MIN     = 32'h8000_0000;
  localparam logic [QBITS-1:0] NEG_MAG_MAX = 32'h8000_0000;

  // control that travels with each transaction
  typedef struct packed {
    logic valid;
    logic bad;
  } ctl_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // width of t*k*dp*2^F + T*g*A
  function automatic int sum_width(input int f);
    return max2(B_W, CP_W + f) + 1;
  endfunction

  // width of the full numerator N
  function automatic int num_width(input int f);
    return max2(sum_width(f) + G_W, PT_W + f) + 1;
  endfunction

  // width of the denominator D = T^3 * 2^F
  function automatic int den_width(input int f);
    return TCUBE_W + f;
  endfunction

endpackage

>>> rtl/core/chi_wmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi_wmul
// Two-stage signed multiply of a wide operand by a narrow one: 32-bit slices
// of the wide operand are multiplied in stage one and summed in stage two.
// ----------------------------------------------------------------------------
module chi_wmul #(
  parameter int AW = 64,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NC  = (AW + 31) / 32;
  localparam int AXW = NC * 32;
  localparam int PW  = 33 + BW;
  localparam int SMW = AXW + BW;

  logic signed [AXW-1:0] ax;
  logic signed [32:0]    ch [NC];
  logic signed [PW-1:0]  pp [NC];
  logic signed [SMW-1:0] acc;

  assign ax = AXW'(a);

  // slice the wide operand; only the top slice carries the sign
  always_comb begin
    for (int i = 0; i < NC; i++) begin
      if (i == NC - 1) begin
        ch[i] = {ax[AXW-1], ax[32*i +: 32]};
      end else begin
        ch[i] = {1'b0, ax[32*i +: 32]};
      end
    end
  end

  // stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NC; i++) begin
        pp[i] <= ch[i] * b;
      end
    end
  end

  // align and add partial products
  always_comb begin
    acc = '0;
    for (int i = 0; i < NC; i++) begin
      acc = acc + (SMW'(pp[i]) <<< (32 * i));
    end
  end

  // stage 2: product
  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[AW+BW-1:0];
    end
  end

endmodule

>>> rtl/core/chi_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi_poly
// Numerator and denominator pipeline: N = P0*D + t*(dp*t*k*2^F + T*g*A),
// A = v0*g - v1*t, g = T - t, k = 3T - 2t, D = T^3 * 2^F. Input capture
// plus ten stages.
// ----------------------------------------------------------------------------
module chi_poly #(
  parameter  int TIME_FRAC_BITS = chi_pkg::TIME_FRAC_BITS_DEF,
  localparam int NW = chi_pkg::num_width(TIME_FRAC_BITS),
  localparam int DW = chi_pkg::den_width(TIME_FRAC_BITS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [31:0]         elapsed_time,
  input  logic [31:0]         segment_duration,
  input  logic signed [31:0]  start_position,
  input  logic signed [31:0]  end_position,
  input  logic signed [31:0]  start_velocity,
  input  logic signed [31:0]  end_velocity,
  output chi_pkg::ctl_t       ctl_o,
  output logic signed [NW-1:0] num,
  output logic [DW-1:0]       den
);

  localparam int F  = TIME_FRAC_BITS;
  localparam int SW = chi_pkg::sum_width(TIME_FRAC_BITS);
  localparam int MW = SW + chi_pkg::G_W;
  localparam int GW = chi_pkg::G_W;

  // stage 0: input capture
  logic [31:0]        t0, tdur0;
  logic signed [31:0] p0_0, p1_0, v0_0, v1_0;
  chi_pkg::ctl_t      ctl0;
  chi_pkg::ctl_t      ctl_d [1:10];

  // stage 1
  logic signed [GW-1:0]           tz, tdz, g;
  logic signed [32:0]             dp;
  logic signed [chi_pkg::K_W-1:0] k;
  logic signed [64:0]             a1, a2;
  logic signed [chi_pkg::C1_W-1:0] c1;
  logic [chi_pkg::TT_W-1:0]       tt;

  // delay lines
  logic [31:0]          t_d   [1:7];
  logic [31:0]          tdur_d [1:4];
  logic signed [GW-1:0] g_d   [1:2];
  logic signed [31:0]   p0_d  [1:3];

  // later stages
  logic signed [chi_pkg::A_W-1:0]  a_r;
  logic signed [chi_pkg::CP_W-1:0] cp;
  logic signed [chi_pkg::CP_W-1:0] cp_d [1:3];
  logic signed [chi_pkg::T3_W-1:0] t3;
  logic signed [chi_pkg::T3_W-1:0] t3_d [1:6];
  logic signed [chi_pkg::GA_W-1:0] ga;
  logic signed [chi_pkg::B_W-1:0]  bt;
  logic signed [chi_pkg::PT_W-1:0] pt;
  logic signed [chi_pkg::PT_W-1:0] pt_d [1:4];
  logic signed [SW-1:0]            s_r;
  logic signed [MW-1:0]            m_r;

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
      for (int i = 1; i <= 10; i++) begin
        ctl_d[i] <= '0;
      end
    end else if (en) begin
      ctl0.valid <= in_valid;
      ctl0.bad   <= (segment_duration == '0);
      ctl_d[1]   <= ctl0;
      for (int i = 2; i <= 10; i++) begin
        ctl_d[i] <= ctl_d[i-1];
      end
    end
  end

  assign ctl_o = ctl_d[10];

  // signed views and first-level terms
  always_comb begin
    tz  = $signed({1'b0, t0});
    tdz = $signed({1'b0, tdur0});
    g   = tdz - tz;
    dp  = 33'(p1_0) - 33'(p0_0);
    k   = (chi_pkg::K_W'(tdz) <<< 1) + chi_pkg::K_W'(tdz) - (chi_pkg::K_W'(tz) <<< 1);
  end

  // stages 0..2, delay lines and the final sums
  always_ff @(posedge clk) begin
    if (en) begin
      t0    <= elapsed_time;
      tdur0 <= segment_duration;
      p0_0  <= start_position;
      p1_0  <= end_position;
      v0_0  <= start_velocity;
      v1_0  <= end_velocity;

      a1 <= v0_0 * g;
      a2 <= v1_0 * tz;
      c1 <= dp * k;
      tt <= tdur0 * tdur0;

      a_r <= chi_pkg::A_W'(a1) - chi_pkg::A_W'(a2);

      t_d[1]    <= t0;
      tdur_d[1] <= tdur0;
      g_d[1]    <= g;
      p0_d[1]   <= p0_0;
      for (int i = 2; i <= 7; i++) t_d[i] <= t_d[i-1];
      for (int i = 2; i <= 4; i++) tdur_d[i] <= tdur_d[i-1];
      g_d[2] <= g_d[1];
      for (int i = 2; i <= 3; i++) p0_d[i] <= p0_d[i-1];

      cp_d[1] <= cp;
      for (int i = 2; i <= 3; i++) cp_d[i] <= cp_d[i-1];
      pt_d[1] <= pt;
      for (int i = 2; i <= 4; i++) pt_d[i] <= pt_d[i-1];
      t3_d[1] <= t3;
      for (int i = 2; i <= 6; i++) t3_d[i] <= t3_d[i-1];

      // stage 7: inner sum
      s_r <= SW'(bt) + (SW'(cp_d[3]) <<< F);
      // stage 10: numerator and denominator
      num <= NW'(m_r) + (NW'(pt_d[4]) <<< F);
      den <= DW'(t3_d[6][chi_pkg::TCUBE_W-1:0]) << F;
    end
  end

  // dp*k*t, ready at stage 3
  chi_wmul #(.AW(chi_pkg::C1_W), .BW(GW)) u_cp (
    .clk(clk), .en(en), .a(c1), .b($signed({1'b0, t_d[1]})), .p(cp)
  );

  // T^3, ready at stage 3
  chi_wmul #(.AW(chi_pkg::TT_W + 1), .BW(GW)) u_t3 (
    .clk(clk), .en(en), .a($signed({1'b0, tt})), .b($signed({1'b0, tdur_d[1]})), .p(t3)
  );

  // g*A, ready at stage 4
  chi_wmul #(.AW(chi_pkg::A_W), .BW(GW)) u_ga (
    .clk(clk), .en(en), .a(a_r), .b(g_d[2]), .p(ga)
  );

  // T*g*A, ready at stage 6
  chi_wmul #(.AW(chi_pkg::GA_W), .BW(GW)) u_bt (
    .clk(clk), .en(en), .a(ga), .b($signed({1'b0, tdur_d[4]})), .p(bt)
  );

  // p0*T^3, ready at stage 5
  chi_wmul #(.AW(chi_pkg::T3_W), .BW(32)) u_pt (
    .clk(clk), .en(en), .a(t3), .b(p0_d[3]), .p(pt)
  );

  // t*(inner sum), ready at stage 9
  chi_wmul #(.AW(SW), .BW(GW)) u_m (
    .clk(clk), .en(en), .a(s_r), .b($signed({1'b0, t_d[7]})), .p(m_r)
  );

endmodule

>>> rtl/core/chi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chi_div
// Rounding divider: q = floor((2|N| + D) / 2D), one restoring quotient bit
// per stage, then saturation to 32 bits. 36 stages.
// ----------------------------------------------------------------------------
module chi_div #(
  parameter  int TIME_FRAC_BITS = chi_pkg::TIME_FRAC_BITS_DEF,
  localparam int NW = chi_pkg::num_width(TIME_FRAC_BITS),
  localparam int DW = chi_pkg::den_width(TIME_FRAC_BITS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  chi_pkg::ctl_t        ctl_i,
  input  logic signed [NW-1:0] num,
  input  logic [DW-1:0]        den,
  output chi_pkg::ctl_t        ctl_o,
  output logic signed [31:0]   pos,
  output logic                 ovf,
  output logic                 bad
);

  localparam int QB = chi_pkg::QBITS;
  localparam int UW = chi_pkg::max2(NW + 1, DW) + 1;
  localparam int VW = DW + 1;
  localparam int CW = chi_pkg::max2(UW - QB, VW);

  // stage A: magnitude
  logic [NW-1:0] mag;
  logic [DW-1:0] den_a;
  logic          neg_a;
  chi_pkg::ctl_t ctl_a;

  // stage B: rounded dividend and doubled divisor
  logic [UW-1:0] u;
  logic [VW-1:0] v_b;
  logic          neg_b;
  chi_pkg::ctl_t ctl_b;
  logic          hi;

  // quotient stages
  logic [VW-1:0] st_r   [QB+1];
  logic [VW-1:0] st_v   [QB+1];
  logic [QB-1:0] st_l   [QB+1];
  logic [QB-1:0] st_q   [QB+1];
  logic          st_neg [QB+1];
  logic          st_hi  [QB+1];
  chi_pkg::ctl_t st_ctl [QB+1];

  logic [VW:0]   rs [QB];
  logic [VW-1:0] rn [QB];
  logic          qb [QB];

  logic [QB-1:0] q;
  logic          ovf_c;

  // quotient would reach 2^32 or more
  assign hi = CW'(u >> QB) >= CW'(v_b);

  // one restoring step per stage
  always_comb begin
    for (int j = 0; j < QB; j++) begin
      rs[j] = {st_r[j], st_l[j][QB-1]};
      qb[j] = rs[j] >= {1'b0, st_v[j]};
      rn[j] = qb[j] ? VW'(rs[j] - {1'b0, st_v[j]}) : VW'(rs[j]);
    end
  end

  // control pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
      ctl_b <= '0;
      for (int j = 0; j <= QB; j++) st_ctl[j] <= '0;
      ctl_o <= '0;
    end else if (en) begin
      ctl_a     <= ctl_i;
      ctl_b     <= ctl_a;
      st_ctl[0] <= ctl_b;
      for (int j = 0; j < QB; j++) st_ctl[j+1] <= st_ctl[j];
      ctl_o <= st_ctl[QB];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      neg_a <= num[NW-1];
      mag   <= num[NW-1] ? NW'(-num) : NW'(num);
      den_a <= den;

      u     <= UW'({mag, 1'b0}) + UW'(den_a);
      v_b   <= {den_a, 1'b0};
      neg_b <= neg_a;

      st_r[0]   <= VW'(u >> QB);
      st_l[0]   <= u[QB-1:0];
      st_v[0]   <= v_b;
      st_q[0]   <= '0;
      st_neg[0] <= neg_b;
      st_hi[0]  <= hi;
      for (int j = 0; j < QB; j++) begin
        st_r[j+1]   <= rn[j];
        st_l[j+1]   <= st_l[j] << 1;
        st_v[j+1]   <= st_v[j];
        st_q[j+1]   <= {st_q[j][QB-2:0], qb[j]};
        st_neg[j+1] <= st_neg[j];
        st_hi[j+1]  <= st_hi[j];
      end
    end
  end

  // saturation
  assign q     = st_q[QB];
  assign ovf_c = st_hi[QB] || (!st_neg[QB] && q[QB-1]) ||
                 (st_neg[QB] && (q > chi_pkg::NEG_MAG_MAX));

  always_ff @(posedge clk) begin
    if (en) begin
      bad <= st_ctl[QB].bad;
      if (st_ctl[QB].bad) begin
        pos <= '0;
        ovf <= 1'b0;
      end else if (ovf_c) begin
        pos <= st_neg[QB] ? chi_pkg::POS_MIN : chi_pkg::POS_MAX;
        ovf <= 1'b1;
      end else begin
        pos <= st_neg[QB] ? -q : q;
        ovf <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/cubic_hermite_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_hermite_interpolator_core
// Each result passes through 11 register stages of numerator pipeline, 36 of
// divider and one output stage. Throughput: one transaction per cycle while
// the skid entry is empty; every stage is fully pipelined.
// Reset clears all valid bits and the output skid stage; data is not reset.
// ----------------------------------------------------------------------------
module cubic_hermite_interpolator_core #(
  parameter int TIME_FRAC_BITS = chi_pkg::TIME_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        elapsed_time,
  input  logic [31:0]        segment_duration,
  input  logic signed [31:0] start_position,
  input  logic signed [31:0] end_position,
  input  logic signed [31:0] start_velocity,
  input  logic signed [31:0] end_velocity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] interpolated_position,
  output logic               overflow,
  output logic               bad_duration
);

  localparam int NW = chi_pkg::num_width(TIME_FRAC_BITS);
  localparam int DW = chi_pkg::den_width(TIME_FRAC_BITS);

  logic                 en;
  chi_pkg::ctl_t        ctl_p, ctl_r;
  logic signed [NW-1:0] num;
  logic [DW-1:0]        den;
  logic signed [31:0]   r_pos;
  logic                 r_ovf, r_bad;

  logic                 skid_v;
  logic signed [31:0]   skid_pos;
  logic                 skid_ovf, skid_bad;

  // pipeline moves whenever the skid stage is free
  assign en       = !skid_v;
  assign in_stall = skid_v;

  chi_poly #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_poly (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .elapsed_time(elapsed_time), .segment_duration(segment_duration),
    .start_position(start_position), .end_position(end_position),
    .start_velocity(start_velocity), .end_velocity(end_velocity),
    .ctl_o(ctl_p), .num(num), .den(den)
  );

  chi_div #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .ctl_i(ctl_p), .num(num), .den(den),
    .ctl_o(ctl_r), .pos(r_pos), .ovf(r_ovf), .bad(r_bad)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!skid_v) begin
      if (ctl_r.valid) begin
        if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
        end else begin
          skid_v <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end else if (!out_stall) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      if (ctl_r.valid) begin
        if (!out_valid || !out_stall) begin
          interpolated_position <= r_pos;
          overflow              <= r_ovf;
          bad_duration          <= r_bad;
        end else begin
          skid_pos <= r_pos;
          skid_ovf <= r_ovf;
          skid_bad <= r_bad;
        end
      end
    end else if (!out_stall) begin
      interpolated_position <= skid_pos;
      overflow              <= skid_ovf;
      bad_duration          <= skid_bad;
    end
  end

  // skid entry only exists behind a held output
  assert property (@(posedge clk) disable iff (rst) skid_v |-> out_valid)
    else $error("skid entry without output transaction");

  // zero duration forces a clean zero result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_duration |-> interpolated_position == '0 && !overflow)
    else $error("bad duration result not zero");

  // overflow only with a saturated position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      interpolated_position == chi_pkg::POS_MAX || interpolated_position == chi_pkg::POS_MIN)
    else $error("overflow without saturation");

  // a skid entry drains as soon as the output is taken
  assert property (@(posedge clk) disable iff (rst)
    skid_v && !out_stall |=> out_valid && !skid_v)
    else $error("skid entry not drained");

endmodule

>>> dv/tb_cubic_hermite_interpolator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_hermite_interpolator_core
// Self-checking bench for the cubic Hermite interpolator core. A directed
// table covers zero duration, segment endpoints, extremes and extrapolation.
// A random phase of joint samples follows, with bursty input and random
// output stall. Each result not given by a typed row is compared with an exact wide-integer predictor.
// ----------------------------------------------------------------------------
module tb_cubic_hermite_interpolator_core;

  localparam int TFB = chi_pkg::TIME_FRAC_BITS_DEF;
  localparam int LATENCY = 47;
  localparam int N_RANDOM = 1400;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        elapsed_time;
  logic [31:0]        segment_duration;
  logic signed [31:0] start_position;
  logic signed [31:0] end_position;
  logic signed [31:0] start_velocity;
  logic signed [31:0] end_velocity;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] interpolated_position;
  logic               overflow;
  logic               bad_duration;

  typedef struct {
    logic [31:0]        t;
    logic [31:0]        dur;
    logic signed [31:0] p0;
    logic signed [31:0] p1;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
  } sample_t;

  typedef struct {
    logic signed [31:0] pos;
    logic               ovf;
    logic               bad;
  } position_t;

  typedef struct {
    sample_t   s;
    bit        typed;
    position_t want;
  } row_t;

  typedef enum int {
    STALL_FREE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_t;

  position_t   pending_positions[$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_ovf = 0;
  int          n_bad = 0;
  stall_mode_t stall_mode = STALL_FREE;

  cubic_hermite_interpolator_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .elapsed_time(elapsed_time), .segment_duration(segment_duration),
    .start_position(start_position), .end_position(end_position),
    .start_velocity(start_velocity), .end_velocity(end_velocity),
    .out_valid(out_valid), .out_stall(out_stall),
    .interpolated_position(interpolated_position),
    .overflow(overflow), .bad_duration(bad_duration)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // exact Hermite position: round(N/D) half away from zero, then saturate
  function automatic position_t hermite_position(input sample_t s);
    logic signed [255:0] t, tt, p0, dp, v0, v1, k, g, n, d, tsc;
    logic [255:0] mag, q;
    logic neg;
    position_t r;
    r.pos = '0;
    r.ovf = 1'b0;
    r.bad = 1'b0;
    if (s.dur == 32'd0) begin
      r.bad = 1'b1;
      return r;
    end
    t   = {224'd0, s.t};
    tt  = {224'd0, s.dur};
    p0  = {{224{s.p0[31]}}, s.p0};
    dp  = {{224{s.p1[31]}}, s.p1} - p0;
    v0  = {{224{s.v0[31]}}, s.v0};
    v1  = {{224{s.v1[31]}}, s.v1};
    tsc = 256'sd1 <<< TFB;
    k   = 3 * tt - 2 * t;
    g   = tt - t;
    d   = tt * tt * tt * tsc;
    n   = p0 * d + dp * t * t * k * tsc + v0 * t * tt * g * g - v1 * tt * t * t * g;
    neg = n[255];
    mag = neg ? -n : n;
    q   = (2 * mag + d) / (2 * d);
    if (neg) r.ovf = q > 256'h8000_0000;
    else r.ovf = q > 256'h7fff_ffff;
    if (r.ovf) r.pos = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else r.pos = neg ? -q[31:0] : q[31:0];
    return r;
  endfunction

  // present one transaction and hold it until accepted
  task automatic drive_sample(input sample_t s, input bit typed, input position_t want);
    elapsed_time     <= s.t;
    segment_duration <= s.dur;
    start_position   <= s.p0;
    end_position     <= s.p1;
    start_velocity   <= s.v0;
    end_velocity     <= s.v1;
    in_valid         <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_positions.insert(pending_positions.size(),
                             typed ? want : hermite_position(s));
    n_sent++;
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_small_pos();
    return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int kind;
    kind = $urandom_range(0, 99);
    s.dur = $urandom_range(32'h0000_1000, 32'h0040_0000);
    s.t   = $urandom_range(0, s.dur);
    s.p0  = rand_small_pos();
    s.p1  = rand_small_pos();
    s.v0  = rand_small_pos();
    s.v1  = rand_small_pos();
    if (kind < 10) begin
      // fully random fields: every bit toggles, overflow is common
      s.t = $urandom; s.dur = $urandom; s.p0 = $urandom; s.p1 = $urandom;
      s.v0 = $urandom; s.v1 = $urandom;
    end else if (kind < 15) begin
      s.dur = 32'd0;
    end else if (kind < 25) begin
      // extrapolation past the segment end
      s.t = s.dur + $urandom_range(0, s.dur);
    end else if (kind < 30) begin
      s.p0 = 32'sh7ff0_0000 + $signed($urandom_range(0, 32'h000f_ffff));
      s.p1 = s.p0;
      s.v0 = $urandom;
    end
    return s;
  endfunction

  // output stall pattern: free, random, or heavy
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= stall_mode_t'($urandom_range(0, 2));
      case (stall_mode)
        STALL_FREE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    position_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_positions.size() == 0) begin
        $display("%0t unexpected result pos=%h ovf=%b bad=%b", $time,
                 interpolated_position, overflow, bad_duration);
        errors++;
      end else begin
        w = pending_positions.pop_front();
        n_checked++;
        if (overflow) n_ovf++;
        if (bad_duration) n_bad++;
        if (interpolated_position !== w.pos) begin
          $display("%0t position mismatch expected=%h actual=%h", $time, w.pos,
                   interpolated_position);
          errors++;
        end
        if (overflow !== w.ovf) begin
          $display("%0t overflow mismatch expected=%b actual=%b", $time, w.ovf, overflow);
          errors++;
        end
        if (bad_duration !== w.bad) begin
          $display("%0t bad_duration mismatch expected=%b actual=%b", $time, w.bad,
                   bad_duration);
          errors++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #(8 * 400000);
    $display("timeout with %0d results outstanding", pending_positions.size());
    $display("[cubic_hermite_interpolator_core] ERROR");
    $finish;
  end

  initial begin
    row_t      dir[$];
    row_t      r;
    position_t none;
    int        burst;
    none = '{pos: 32'sd0, ovf: 1'b0, bad: 1'b0};

    rst = 1'b1;
    in_valid = 1'b0;
    elapsed_time = '0; segment_duration = '0;
    start_position = '0; end_position = '0;
    start_velocity = '0; end_velocity = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table: typed rows are zero duration and segment endpoints
    dir.insert(dir.size(), '{'{32'h0010_0000, 32'd0, 32'sh1234_5678, -32'sd5, 32'sd7,
                           32'sd9}, 1, '{32'sd0, 1'b0, 1'b1}});
    dir.insert(dir.size(), '{'{32'hffff_ffff, 32'd0, 32'sh7fff_ffff, 32'sh8000_0000,
                           32'sh7fff_ffff, 32'sh8000_0000}, 1, '{32'sd0, 1'b0, 1'b1}});
    dir.insert(dir.size(), '{'{32'd0, 32'h0010_0000, 32'sh0001_0000, 32'sh0005_0000,
                           32'sd3, -32'sd4}, 1, '{32'sh0001_0000, 1'b0, 1'b0}});
    dir.insert(dir.size(), '{'{32'd0, 32'hffff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                           32'sh7fff_ffff, 32'sh7fff_ffff}, 1,
                           '{32'sh8000_0000, 1'b0, 1'b0}});
    dir.insert(dir.size(), '{'{32'd0, 32'd1, 32'sh7fff_ffff, 32'sh8000_0000,
                           32'sh8000_0000, 32'sh8000_0000}, 1,
                           '{32'sh7fff_ffff, 1'b0, 1'b0}});
    dir.insert(dir.size(), '{'{32'h0020_0000, 32'h0020_0000, -32'sd100, 32'sh7fff_ffff,
                           32'sd0, 32'sd0}, 1, '{32'sh7fff_ffff, 1'b0, 1'b0}});
    dir.insert(dir.size(), '{'{32'hffff_ffff, 32'hffff_ffff, 32'sd0, 32'sh8000_0000,
                           32'sh7fff_ffff, 32'sh8000_0000}, 1,
                           '{32'sh8000_0000, 1'b0, 1'b0}});
    dir.insert(dir.size(), '{'{32'h0008_0000, 32'h0010_0000, 32'sd0, 32'sh0001_0000,
                           32'sd0, 32'sd0}, 0, none});
    dir.insert(dir.size(), '{'{32'h0008_0000, 32'h0010_0000, 32'sd0, 32'sd0,
                           32'sh0002_0000, -32'sh0002_0000}, 0, none});
    dir.insert(dir.size(), '{'{32'd1, 32'd3, 32'sd0, 32'sd1, 32'sd0, 32'sd0}, 0, none});
    dir.insert(dir.size(), '{'{32'd1, 32'd2, 32'sd0, 32'sd1, 32'sd0, 32'sd0}, 0, none});
    dir.insert(dir.size(), '{'{32'd1, 32'd2, 32'sd0, -32'sd1, 32'sd0, 32'sd0}, 0, none});
    dir.insert(dir.size(), '{'{32'hffff_ffff, 32'd1, 32'sh7fff_ffff, 32'sh8000_0000,
                           32'sh7fff_ffff, 32'sh8000_0000}, 0, none});
    dir.insert(dir.size(), '{'{32'hffff_ffff, 32'd1, 32'sh8000_0000, 32'sh7fff_ffff,
                           32'sh8000_0000, 32'sh7fff_ffff}, 0, none});
    dir.insert(dir.size(), '{'{32'h0030_0000, 32'h0010_0000, 32'sd0, 32'sh0001_0000,
                           32'sh0001_0000, 32'sh0001_0000}, 0, none});
    dir.insert(dir.size(), '{'{32'h0001_0000, 32'hffff_ffff, 32'sh8000_0000,
                           32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, none});
    dir.insert(dir.size(), '{'{32'h0040_0000, 32'h0010_0000, 32'sh7ff0_0000,
                           32'sh7ff0_0000, 32'sh7fff_ffff, 32'sd0}, 0, none});
    dir.insert(dir.size(), '{'{32'h0040_0000, 32'h0010_0000, 32'sh8010_0000,
                           32'sh8010_0000, 32'sh8000_0000, 32'sd0}, 0, none});
    foreach (dir[i]) begin
      r = dir[i];
      drive_sample(r.s, r.typed, r.want);
    end

    // random joint samples in bursts
    while (n_sent < N_RANDOM + dir.size()) begin
      burst = $urandom_range(1, 40);
      repeat (burst) drive_sample(random_sample(), 0, none);
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
      if (n_sent > 700 && n_sent < 741) begin
        // drain the pipeline completely at least once mid-run
        in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending_positions.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("sent %0d joint samples, checked %0d results (%0d saturated, %0d zero duration)",
             n_sent, n_checked, n_ovf, n_bad);
    if (errors == 0) begin
      $display("[cubic_hermite_interpolator_core] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[cubic_hermite_interpolator_core] ERROR");
    end
    $finish;
  end

endmodule
